// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, codes and constants of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 56;

  // operation codes carried in the input tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic        [7:0]  prio;
    logic        [7:0]  sys;
    logic        [7:0]  res;
    logic        [7:0]  stat;
    logic signed [15:0] amt;
  } rec_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP
  } cmd_e;

  // broadcast from the control to every cell
  typedef struct packed {
    cmd_e cmd;
    rec_t rec;
  } ctrl_t;

endpackage

// ===== sv/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue of event records built as a chain of sorted cells
// ----------------------------------------------------------------------------
//
// channel   dir  tdata                                        tuser
// s_axis    in   prio, sys, res, status, amount (48 bits)     op
// m_axis    out  prio, sys, res, status, amount, occupancy    ok
//
// one beat per cycle while s_axis_tready is high: every cell compares and shifts in the same cycle
// the result beat is captured in the output register on acceptance
// s_axis_tready drops only while a result waits and m_axis_tready is low
// reset empties the queue; record cells hold no reset value
// equal priorities leave in arrival order
//
module stable_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] prio, [15:8] system id, [23:16] resource id, [31:24] status,
  // [47:32] amount
  input  logic [spq_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [0] op
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] prio, [15:8] system id, [23:16] resource id, [31:24] status,
  // [47:32] amount, [52:48] occupancy, [55:53] zero
  output logic [spq_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [0] ok
  output logic                            m_axis_tuser_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = spq_pkg::OCC_W;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             ok_q, ok_d;
  spq_pkg::rec_t    res_q, res_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  spq_pkg::ctrl_t   ctrl;
  spq_pkg::rec_t    in_rec;
  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  logic             keep [DEPTH];
  spq_pkg::rec_t    recs [DEPTH];

  // incoming record unpacked from the low bits up
  assign in_rec.prio = s_axis_tdata_i[7:0];
  assign in_rec.sys  = s_axis_tdata_i[15:8];
  assign in_rec.res  = s_axis_tdata_i[23:16];
  assign in_rec.stat = s_axis_tdata_i[31:24];
  assign in_rec.amt  = s_axis_tdata_i[47:32];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // command broadcast to the chain; full pushes and empty pops hold it
  always_comb begin
    ctrl.rec = in_rec;
    ctrl.cmd = spq_pkg::CMD_HOLD;
    if (accept) begin
      if (s_axis_tuser_i == spq_pkg::OP_PUSH) begin
        if (!full) begin
          ctrl.cmd = spq_pkg::CMD_PUSH;
        end
      end else if (!empty) begin
        ctrl.cmd = spq_pkg::CMD_POP;
      end
    end
  end

  // cell chain, cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          occ;
    logic          left_keep;
    spq_pkg::rec_t left_rec;
    spq_pkg::rec_t right_rec;

    assign occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_rec  = in_rec;
    end else begin : g_body
      assign left_keep = keep[i-1];
      assign left_rec  = recs[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = recs[i];
    end else begin : g_inner
      assign right_rec = recs[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_keep_i (left_keep),
      .left_rec_i  (left_rec),
      .right_rec_i (right_rec),
      .keep_o      (keep[i]),
      .rec_o       (recs[i])
    );
  end

  // fill count and result beat
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    res_d       = res_q;
    case (ctrl.cmd)
      spq_pkg::CMD_PUSH: count_d = count_q + CNT_W'(1);
      spq_pkg::CMD_POP:  count_d = count_q - CNT_W'(1);
      default:           count_d = count_q;
    endcase
    occ_wide = {{OCC_W{1'b0}}, count_d};
    occ_d    = occ_wide[OCC_W-1:0];
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      ok_d        = (ctrl.cmd != spq_pkg::CMD_HOLD);
      // popped head leaves with the beat, all other beats report zero fields
      res_d       = (ctrl.cmd == spq_pkg::CMD_POP) ? recs[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q  <= ok_d;
      res_q <= res_d;
      occ_q <= occ_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = ok_q;
  assign m_axis_tdata_o  = {3'b000, occ_q, res_q.amt, res_q.stat, res_q.res,
                            res_q.sys, res_q.prio};

`ifndef ASSERT_OFF
  // fill count never passes the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // a stored push grows the queue by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.cmd == spq_pkg::CMD_PUSH |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the queue");

  // a pop returns the head priority with ok set
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.cmd == spq_pkg::CMD_POP |=>
      m_axis_tuser_o && m_axis_tdata_o[7:0] == $past(recs[0].prio))
    else $error("pop did not return the head");

  // the head is never outranked by its neighbor
  if (DEPTH > 1) begin : g_order_chk
    a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q > CNT_W'(1) |-> recs[0].prio >= recs[1].prio)
      else $error("chain out of order at the head");
  end

  // input stalls only behind a waiting result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled without a waiting result");
`endif

endmodule

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain, holds a record and trades with its neighbors
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic            clk_i,
  input  spq_pkg::ctrl_t  ctrl_i,
  input  logic            occ_i,        // slot holds a live record
  input  logic            left_keep_i,  // left neighbor keeps its record
  input  spq_pkg::rec_t   left_rec_i,
  input  spq_pkg::rec_t   right_rec_i,
  output logic            keep_o,
  output spq_pkg::rec_t   rec_o
);

  spq_pkg::rec_t rec_q, rec_d;

  // a live record stays in place on a push when its priority is greater or equal, so ties keep order
  assign keep_o = occ_i && (rec_q.prio >= ctrl_i.rec.prio);
  assign rec_o  = rec_q;

  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.cmd)
      spq_pkg::CMD_PUSH: begin
        if (!keep_o) begin
          rec_d = left_keep_i ? ctrl_i.rec : left_rec_i;
        end
      end
      spq_pkg::CMD_POP: begin
        rec_d = right_rec_i;
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule
